@@ rtl/isl_pkg.sv @@
// Package: shared types and constants of the indexed shift list.
`timescale 1ns / 1ps
`default_nettype none
package isl_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 7;
	localparam int CNT_W  = 7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_ERASE  = 2'd1,
		OP_READ   = 2'd2,
		OP_WRITE  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage
`default_nettype wire

@@ rtl/isl_req_if.sv @@
// Interface: request channel (opcode, position, value) with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface isl_req_if import isl_pkg::*; ();
	logic                     valid;
	logic                     ready;
	opcode_t                  opcode;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output opcode, output position, output value, input ready);
	modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface
`default_nettype wire

@@ rtl/isl_rsp_if.sv @@
// Interface: response channel (data, status, count) with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface isl_rsp_if import isl_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] data;
	status_t                  status;
	logic [CNT_W-1:0]         count;

	modport source (output valid, output data, output status, output count, input ready);
	modport sink   (input valid, input data, input status, input count, output ready);
endinterface
`default_nettype wire

@@ rtl/isl_ram.sv @@
// Simple dual-port element RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module isl_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/indexed_shift_list.sv @@
// Top level: ordered list engine with insert, erase, read and write at a position.
//
// Usage:
//   req carries one request word: opcode, position and value. rsp returns one
//   word per request: data (element read or removed, else zero), status and
//   the element count after the request. Both channels complete a word when
//   valid and ready are high at a rising edge of clk.
// State sequence per request (one request at a time):
//   read or erase of the last element: S_IDLE, S_RDATA, S_EMIT, then rsp
//   write, insert at the end, or any error: S_IDLE, S_EMIT, then rsp
//   insert at position p: S_INS_SH once per element from p up, S_INS_FIN, S_EMIT
//   erase at position p (not the last): S_RDATA, S_ER_SH per element above p, S_EMIT
//   The element RAM has one write and one read port; each shift step reads
//   one entry and writes back the neighbor read in the previous cycle.
// Stall: a finished response sits in the rsp output register; the next
//   request is already accepted and worked on, and its response waits in
//   the final state until the output register frees up.
// Reset: arst_n clears the count and all control state. The RAM is not
//   cleared; entries at or above the count never reach a response.
`timescale 1ns / 1ps
`default_nettype none
module indexed_shift_list import isl_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	isl_req_if.sink   req,
	isl_rsp_if.source rsp
);

	// count width holds CAPACITY itself; compare width covers the position field too
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int AW   = $clog2(CAPACITY);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_RDATA   = 6'b000010,
		S_INS_SH  = 6'b000100,
		S_INS_FIN = 6'b001000,
		S_ER_SH   = 6'b010000,
		S_EMIT    = 6'b100000
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            idx_q;
	logic [CW-1:0]            pos_q;
	opcode_t                  op_q;
	logic [DATA_W-1:0]        val_q;
	logic [DATA_W-1:0]        res_data_q;
	status_t                  res_status_q;
	logic                     rsp_valid_q;
	logic [DATA_W-1:0]        rsp_data_q;
	status_t                  rsp_status_q;
	logic [CNT_W-1:0]         rsp_count_q;

	logic                     accept;
	logic                     emit_fire;
	logic [CMPW-1:0]          pos_ext;
	logic [CMPW-1:0]          cnt_ext;
	logic                     range_err;
	logic                     full;
	logic [AW-1:0]            in_addr;
	logic [CW-1:0]            idx_m1;
	logic [CW-1:0]            idx_m2;
	logic [CW-1:0]            idx_p1;
	logic [CW-1:0]            idx_p2;
	logic [CW-1:0]            pos_p1;

	logic                     mem_we;
	logic [AW-1:0]            mem_waddr;
	logic [DATA_W-1:0]        mem_wdata;
	logic [AW-1:0]            mem_raddr;
	logic [DATA_W-1:0]        mem_rdata;

	// Take a request only between requests; the output register decouples rsp.
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign emit_fire = (state_q == S_EMIT) && (!rsp_valid_q || rsp.ready);

	assign pos_ext   = CMPW'(req.position);
	assign cnt_ext   = CMPW'(count_q);
	// insert may address one past the last element, the others may not
	assign range_err = (req.opcode == OP_INSERT) ? (pos_ext > cnt_ext) : (pos_ext >= cnt_ext);
	assign full      = (count_q == CW'(CAPACITY));
	assign in_addr   = AW'(pos_ext);

	assign idx_m1 = idx_q - CW'(1);
	assign idx_m2 = idx_q - CW'(2);
	assign idx_p1 = idx_q + CW'(1);
	assign idx_p2 = idx_q + CW'(2);
	assign pos_p1 = pos_q + CW'(1);

	// RAM port steering. Shift steps read two entries ahead of the write, so
	// a read and a write in the same cycle never hit the same entry.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = in_addr;
		mem_wdata = req.value;
		mem_raddr = in_addr;
		unique case (state_q)
			S_IDLE: begin
				if (req.opcode == OP_INSERT) begin
					mem_raddr = AW'(count_q - CW'(1));
				end
				if (accept && !range_err) begin
					if (req.opcode == OP_WRITE ||
					    (req.opcode == OP_INSERT && !full && pos_ext == cnt_ext)) begin
						mem_we = 1'b1;
					end
				end
			end
			S_RDATA: begin
				mem_raddr = AW'(pos_p1);
			end
			S_INS_SH: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(idx_q);
				mem_wdata = mem_rdata;
				mem_raddr = AW'(idx_m2);
			end
			S_INS_FIN: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(pos_q);
				mem_wdata = val_q;
			end
			S_ER_SH: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(idx_q);
				mem_wdata = mem_rdata;
				mem_raddr = AW'(idx_p2);
			end
			S_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	isl_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW),
		.DW    (DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			pos_q        <= '0;
			op_q         <= OP_INSERT;
			val_q        <= '0;
			res_data_q   <= '0;
			res_status_q <= ST_OK;
			rsp_valid_q  <= 1'b0;
			rsp_data_q   <= '0;
			rsp_status_q <= ST_OK;
			rsp_count_q  <= '0;
		end else begin
			// drop the response word once taken, unless a new one replaces it
			if (emit_fire) begin
				rsp_valid_q  <= 1'b1;
				rsp_data_q   <= res_data_q;
				rsp_status_q <= res_status_q;
				rsp_count_q  <= CNT_W'(count_q);
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q         <= req.opcode;
						pos_q        <= CW'(pos_ext);
						val_q        <= req.value;
						res_data_q   <= '0;
						// a bad position wins over a full list
						res_status_q <= range_err ? ST_RANGE :
						                ((req.opcode == OP_INSERT && full) ? ST_FULL : ST_OK);
						if (range_err) begin
							state_q      <= S_EMIT;
						end else begin
							unique case (req.opcode)
								OP_INSERT: begin
									if (full) begin
										state_q      <= S_EMIT;
									end else if (pos_ext == cnt_ext) begin
										count_q <= count_q + CW'(1);
										state_q <= S_EMIT;
									end else begin
										idx_q   <= count_q;
										state_q <= S_INS_SH;
									end
								end
								OP_ERASE, OP_READ: begin
									state_q <= S_RDATA;
								end
								OP_WRITE: begin
									state_q <= S_EMIT;
								end
								default: begin
									state_q <= S_EMIT;
								end
							endcase
						end
					end
				end
				S_RDATA: begin
					res_data_q <= mem_rdata;
					if (op_q == OP_ERASE) begin
						if (pos_p1 == count_q) begin
							count_q <= count_q - CW'(1);
							state_q <= S_EMIT;
						end else begin
							idx_q   <= pos_q;
							state_q <= S_ER_SH;
						end
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_INS_SH: begin
					// advance downward until the slot at the position is open
					if (idx_m1 == pos_q) begin
						state_q <= S_INS_FIN;
					end else begin
						idx_q <= idx_m1;
					end
				end
				S_INS_FIN: begin
					count_q <= count_q + CW'(1);
					state_q <= S_EMIT;
				end
				S_ER_SH: begin
					// advance upward until the last element has moved down
					if (idx_p2 == count_q) begin
						count_q <= count_q - CW'(1);
						state_q <= S_EMIT;
					end else begin
						idx_q <= idx_p1;
					end
				end
				S_EMIT: begin
					if (emit_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.data   = rsp_data_q;
	assign rsp.status = rsp_status_q;
	assign rsp.count  = rsp_count_q;

	// count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	// insert shift stays between the position and the old count
	a_ins_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_SH) |-> (idx_q > pos_q && idx_q <= count_q))
		else $error("insert shift index out of window");

	// erase shift never writes at or past the last element
	a_er_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ER_SH) |-> (idx_q >= pos_q && idx_p2 <= count_q))
		else $error("erase shift index out of window");

	// an error response carries zero data
	a_err_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_status_q != ST_OK) |-> (rsp_data_q == '0))
		else $error("error response with nonzero data");

	// in the idle state the RAM is written only by an accepted request
	a_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && mem_we) |-> accept)
		else $error("RAM write while idle without a request");

endmodule
`default_nettype wire

@@ tb/indexed_shift_list_tb.sv @@
// Testbench: random and directed requests against a shadow list, responses checked in order.
`timescale 1ns / 1ps
module indexed_shift_list_tb;
	import isl_pkg::*;

	localparam int CAPACITY     = 64;
	localparam int POS_HIGH     = 64;          // largest position the tests send
	localparam int PERIOD       = 10;
	localparam int RESET_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int PHASES       = 10;
	localparam int PHASE_WORDS  = 130;
	localparam int SETTLE       = CAPACITY + 20; // longest shift plus margin
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		status_t                  status;
		logic [CNT_W-1:0]         count;
	} list_result_t;

	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} op_mix_t;

	// Shadow copy of the list: apply each accepted request, queue its response,
	// and compare returned responses against the oldest queued one.
	class shadow_list;
		logic signed [DATA_W-1:0] cells [CAPACITY];
		int           held;
		list_result_t pending_results [$];
		int           mismatches;
		int           checked;
		int           full_hits;
		int           range_hits;
		int           peak;
		int           op_seen [4];

		function new();
			held       = 0;
			mismatches = 0;
			checked    = 0;
			full_hits  = 0;
			range_hits = 0;
			peak       = 0;
			foreach (op_seen[k]) op_seen[k] = 0;
		endfunction

		function void note_request(opcode_t op, logic [POS_W-1:0] pos,
				logic signed [DATA_W-1:0] val);
			list_result_t r;
			int           p;
			int           i;
			p        = int'(pos);
			r.data   = '0;
			r.status = ST_OK;
			case (op)
				OP_INSERT: begin
					if (p > held) begin
						r.status = ST_RANGE;
					end else if (held >= CAPACITY) begin
						r.status = ST_FULL;
					end else begin
						for (i = held; i > p; i--) cells[i] = cells[i-1];
						cells[p] = val;
						held++;
					end
				end
				OP_ERASE: begin
					if (p >= held) begin
						r.status = ST_RANGE;
					end else begin
						r.data = cells[p];
						// only the entries above the removed one move down
						for (i = p; i + 1 < held; i++) cells[i] = cells[i+1];
						held--;
					end
				end
				OP_READ: begin
					if (p >= held) r.status = ST_RANGE;
					else r.data = cells[p];
				end
				default: begin
					if (p >= held) r.status = ST_RANGE;
					else cells[p] = val;
				end
			endcase
			r.count = CNT_W'(held);
			op_seen[int'(op)]++;
			if (r.status == ST_FULL) full_hits++;
			if (r.status == ST_RANGE) range_hits++;
			if (held > peak) peak = held;
			pending_results.insert(pending_results.size(), r);
		endfunction

		function void check_response(logic signed [DATA_W-1:0] data, status_t status,
				logic [CNT_W-1:0] count);
			list_result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: unexpected response: data %0d status %0d count %0d",
						$realtime, data, status, count);
				return;
			end
			want = pending_results[0];
			pending_results.delete(0);
			checked++;
			if (want.data !== data || want.status !== status || want.count !== count) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$write("%0t: response %0d: expected data %0d status %0d count %0d, ",
						$realtime, checked, want.data, want.status, want.count);
					$display("got data %0d status %0d count %0d", data, status, count);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	isl_req_if req_ch ();
	isl_rsp_if rsp_ch ();

	indexed_shift_list #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	shadow_list sb = new();

	int gap_pct;     // chance of a sender gap after each word
	int stall_pct;   // chance that the receiver starts a stall
	int stall_left = 0;
	int cycles = 0;

	initial clk = 1'b0;
	always #(PERIOD / 2) clk = ~clk;

	// Pick an idle length: mostly short, now and then long.
	function automatic int pick_idle();
		if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Drive ready at the falling edge; hold it low for a whole stall once one starts.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
			rsp_ch.ready <= 1'b0;
			stall_left = pick_idle() - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Check every word taken from the response channel at the rising edge.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_response(rsp_ch.data, rsp_ch.status, rsp_ch.count);
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d responses outstanding", $realtime,
				sb.pending_results.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Present one request word at the falling edge, hold it until accepted, then
	// record it in the shadow list and maybe drop valid for a random gap.
	task automatic send_word(opcode_t op, int pos, logic signed [DATA_W-1:0] val);
		@(negedge clk);
		req_ch.valid    <= 1'b1;
		req_ch.opcode   <= op;
		req_ch.position <= POS_W'(pos);
		req_ch.value    <= val;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sb.note_request(op, POS_W'(pos), val);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (pick_idle()) @(posedge clk);
		end
	endtask

	// Drop valid and hold off until every outstanding response has come back.
	task automatic drain_responses();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
	endtask

	// Build one random request. Fill and drain mixes push the list to full and
	// back to empty; positions are mostly in range with the ends favored.
	task automatic random_word(op_mix_t mix, output opcode_t op, output int pos,
			output logic signed [DATA_W-1:0] val);
		int n;
		int r;
		int w_ins;
		int w_era;
		n = sb.held;
		case (mix)
			MIX_FILL:  begin w_ins = 75; w_era = 5;  end
			MIX_DRAIN: begin w_ins = 5;  w_era = 75; end
			default:   begin w_ins = 25; w_era = 25; end
		endcase
		r = $urandom_range(0, 99);
		if (r < w_ins) op = OP_INSERT;
		else if (r < w_ins + w_era) op = OP_ERASE;
		else if (r < w_ins + w_era + (100 - w_ins - w_era) / 2) op = OP_READ;
		else op = OP_WRITE;

		r = $urandom_range(0, 99);
		if (r < 10) pos = 0;
		else if (r < 15) pos = (n > 0) ? n - 1 : 0;
		else if (r < 80) begin
			if (op == OP_INSERT) pos = $urandom_range(0, n);
			else pos = (n > 0) ? $urandom_range(0, n - 1) : 0;
		end else if (r < 90) pos = n;
		else pos = $urandom_range(0, POS_HIGH);

		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0:       val = 32'sh7FFF_FFFF;
				1:       val = 32'sh8000_0000;
				2:       val = '0;
				default: val = -32'sd1;
			endcase
		end else begin
			val = $urandom;
		end
	endtask

	initial begin
		opcode_t                  op;
		int                       pos;
		logic signed [DATA_W-1:0] val;
		op_mix_t                  mix;
		bit                       calm;
		// drive every input to a known value, then hold reset
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.opcode   = OP_INSERT;
		req_ch.position = '0;
		req_ch.value    = '0;
		gap_pct         = 0;
		stall_pct       = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: every operation on an empty list is out of range
		gap_pct   = 25;
		stall_pct = 25;
		send_word(OP_READ, 0, '0);
		send_word(OP_ERASE, 0, '0);
		send_word(OP_WRITE, 0, 32'sh1234_5678);
		send_word(OP_INSERT, 1, 32'sh1111_1111);
		send_word(OP_INSERT, POS_HIGH, 32'sh2222_2222);
		// build a short list: push front, push back, middle insert
		send_word(OP_INSERT, 0, 32'sh7FFF_FFFF);
		send_word(OP_INSERT, 1, 32'sh8000_0000);
		send_word(OP_INSERT, 0, -32'sd1);
		send_word(OP_INSERT, 1, '0);
		send_word(OP_READ, 0, 32'sh7FFF_FFFF);
		send_word(OP_READ, 1, '0);
		send_word(OP_READ, 2, '0);
		send_word(OP_READ, 3, '0);
		send_word(OP_READ, 4, '0);
		send_word(OP_WRITE, 2, 32'sh5A5A_5A5A);
		send_word(OP_READ, 2, '0);
		// middle erase, pop back, pop front
		send_word(OP_ERASE, 1, '0);
		send_word(OP_ERASE, 2, '0);
		send_word(OP_ERASE, 0, '0);
		send_word(OP_READ, 1, '0);
		send_word(OP_WRITE, 1, 32'sh0BAD_F00D);
		send_word(OP_ERASE, 0, '0);
		send_word(OP_ERASE, 0, '0);
		drain_responses();

		// Random phases: fill, drain, even mix in turn, some with no idling at all
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase % 3)
				0:       mix = MIX_FILL;
				1:       mix = MIX_DRAIN;
				default: mix = MIX_EVEN;
			endcase
			calm      = (phase % 4 == 3);
			gap_pct   = calm ? 0 : $urandom_range(5, 40);
			stall_pct = calm ? 0 : $urandom_range(5, 40);
			for (int k = 0; k < PHASE_WORDS; k++) begin
				random_word(mix, op, pos, val);
				send_word(op, pos, val);
			end
			// pause the sender now and then until the list has answered everything
			if (phase % 2 == 1) drain_responses();
		end

		stall_pct = 0;
		drain_responses();
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d inserts, %0d erases, %0d reads, %0d writes; checked %0d responses.",
			sb.op_seen[OP_INSERT], sb.op_seen[OP_ERASE], sb.op_seen[OP_READ],
			sb.op_seen[OP_WRITE], sb.checked);
		$write("List peaked at %0d of %0d entries; %0d full and %0d out-of-range rejects; ",
			sb.peak, CAPACITY, sb.full_hits, sb.range_hits);
		$display("%0d mismatches, %0d outstanding.", sb.mismatches,
			sb.pending_results.size());
		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
